@@ hdl/pcc_pkg.sv @@
// Package: character codes, register indexes and result item type for the column canonicalizer.
package pcc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned Slots   = 3;
  localparam int unsigned CntW    = $clog2(Slots + 1);

  // Character codes
  localparam logic [ByteW-1:0] ChBs  = 8'h08;
  localparam logic [ByteW-1:0] ChTab = 8'h09;
  localparam logic [ByteW-1:0] ChNl  = 8'h0A;
  localparam logic [ByteW-1:0] ChFf  = 8'h0C;
  localparam logic [ByteW-1:0] ChCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChSp  = 8'h20;
  localparam logic [ByteW-1:0] ChPs5 = 8'h05;
  localparam logic [ByteW-1:0] ChPs6 = 8'h06;
  localparam logic [ByteW-1:0] ChSo  = 8'h0E;
  localparam logic [ByteW-1:0] ChSi  = 8'h0F;
  localparam logic [ByteW-1:0] Ch210 = 8'h88;

  localparam logic [ByteW-1:0] MaxColReset = 8'd132;
  localparam logic [ByteW-1:0] ColMax      = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegRawMode   = 1'b0,
    RegMaxColumn = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] repeat_count;
    logic             last_in_run;
  } res_item_t;

endpackage

@@ hdl/printer_column_canonicalizer_top.sv @@
// Top level: line printer column canonicalizer with a three-entry result buffer.
//
// Each accepted character is decoded in the cycle it is accepted: the logical and
// printed columns update at once and the zero to three resulting transactions
// (carriage return, a space run with a repeat count, the character) are loaded
// into a three-slot result buffer that drains one transaction per cycle at the
// output while out_ready_i is high. A character therefore occupies the block until
// its last result leaves, and a character with no result does not hold it. The
// next character is taken in the same cycle the last pending result leaves, so
// sustained rate is set by the single output channel. Configuration writes take
// effect at the clock edge where cfg_we_i is high.
module printer_column_canonicalizer_top
  import pcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // character input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   char_in_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic [ByteW-1:0]   repeat_count_o,
  output logic               last_in_run_o
);

  logic             raw_mode_q;
  logic [ByteW-1:0] max_column_q;
  logic [ByteW-1:0] log_col_q, log_col_d;
  logic [ByteW-1:0] prt_col_q, prt_col_d;
  res_item_t        slot_q [Slots];
  res_item_t        slot_d [Slots];
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic in_acc, out_acc;

  // handshake
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  assign out_byte_o     = slot_q[0].out_byte;
  assign repeat_count_o = slot_q[0].repeat_count;
  assign last_in_run_o  = slot_q[0].last_in_run;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q   <= 1'b0;
      max_column_q <= MaxColReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRawMode:   raw_mode_q   <= cfg_data_i[0];
        RegMaxColumn: max_column_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // character decode
  logic [ByteW:0]     tab_sum;
  logic [ByteW-1:0]   tab_col, inc_col, prt_base, sp_cnt;
  logic               need_cr, in_limit, need_sp;
  logic [CntW-1:0]    n_new;
  logic [ByteW-1:0]   b0, b1, c0;

  always_comb begin
    tab_sum  = ({1'b0, log_col_q} + (ByteW+1)'(8)) & ~(ByteW+1)'(7);
    tab_col  = tab_sum[ByteW] ? ColMax : tab_sum[ByteW-1:0];
    inc_col  = (log_col_q == ColMax) ? ColMax : log_col_q + ByteW'(1);
    need_cr  = log_col_q < prt_col_q;
    prt_base = need_cr ? '0 : prt_col_q;
    in_limit = log_col_q < max_column_q;
    need_sp  = in_limit && (log_col_q > prt_base);
    sp_cnt   = log_col_q - prt_base;

    log_col_d = log_col_q;
    prt_col_d = prt_col_q;
    n_new     = '0;
    b0        = char_in_i;
    c0        = ByteW'(1);
    b1        = char_in_i;

    if (raw_mode_q) begin
      n_new = CntW'(1);
    end else begin
      case (char_in_i)
        ChTab: log_col_d = tab_col;
        ChFf, ChNl: begin
          n_new     = CntW'(1);
          log_col_d = '0;
          prt_col_d = '0;
        end
        ChCr: log_col_d = '0;
        ChBs: log_col_d = (log_col_q == '0) ? '0 : log_col_q - ByteW'(1);
        ChSp: log_col_d = inc_col;
        ChPs5, ChPs6, ChSo, ChSi, Ch210: n_new = CntW'(1);
        default: begin
          // optional CR, optional space run, then the character if below the maximum column
          n_new = CntW'({1'b0, need_cr}) + CntW'({1'b0, need_sp})
                + CntW'({1'b0, in_limit});
          if (need_cr) begin
            prt_col_d = '0;
            b0        = ChCr;
            b1        = need_sp ? ChSp : char_in_i;
          end else if (need_sp) begin
            b0 = ChSp;
            c0 = sp_cnt;
          end
          if (in_limit) prt_col_d = log_col_q + ByteW'(1);
          log_col_d = inc_col;
        end
      endcase
    end
  end

  // result buffer next state
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      slot_d[0].out_byte     = b0;
      slot_d[0].repeat_count = c0;
      slot_d[1].out_byte     = b1;
      slot_d[1].repeat_count = (need_cr && need_sp) ? sp_cnt : ByteW'(1);
      slot_d[2].out_byte     = char_in_i;
      slot_d[2].repeat_count = ByteW'(1);
      for (int i = 0; i < Slots; i++) begin
        slot_d[i].last_in_run = (n_new == CntW'(i + 1));
      end
      cnt_d = n_new;
    end else if (out_acc) begin
      for (int i = 0; i < Slots - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      log_col_q <= '0;
      prt_col_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        log_col_q <= log_col_d;
        prt_col_q <= prt_col_d;
      end
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Slots))
    else $error("result count out of range");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(1)) |-> last_in_run_o)
    else $error("final pending result not marked last");

  a_not_last_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > CntW'(1)) |-> !last_in_run_o)
    else $error("result marked last with more pending");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_byte_o)
      && $stable(repeat_count_o)))
    else $error("stalled result changed");

  a_raw_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && raw_mode_q) |=> (cnt_q == CntW'(1) && out_byte_o == $past(char_in_i)))
    else $error("raw transaction not passed through");

endmodule
